### rtl/utd_pkg.sv
// shared types and constants of the utf-8 to utf-16 decoder
package utd_pkg;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD_E0  = 8'hE0;
    localparam logic [7:0] LEAD_ED  = 8'hED;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD_F0  = 8'hF0;
    localparam logic [7:0] LEAD_F4  = 8'hF4;
    localparam logic [7:0] CONT_A0  = 8'hA0;
    localparam logic [7:0] CONT_90  = 8'h90;
    localparam logic [7:0] CONT_8F  = 8'h8F;

    // job queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_BMP  = 2'd1,
        TAIL_PAIR = 2'd2
    } t_tail;

    // one decoded job: replacement units first, then the tail code point
    typedef struct packed {
        logic [1:0]  n_repl;
        t_tail       tail;
        logic [20:0] cp;
        logic        last;
    } t_job;

endpackage

### rtl/utd_byte_if.sv
// byte stream channel: one utf-8 byte and its end-of-string flag
interface utd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### rtl/utd_unit_if.sv
// code unit channel: one utf-16 code unit and its end flags
interface utd_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        run_end;
    logic        string_end;

    modport source (output valid, output code_unit, output run_end, output string_end,
                    input ready);
    modport sink   (input valid, input code_unit, input run_end, input string_end,
                    output ready);
endinterface

### rtl/utd_front.sv
// front end: sequence tracking, validation and job classification per byte
module utd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output utd_pkg::t_job o_job
);
    import utd_pkg::*;

    logic [7:0]  r_lead, n_lead;
    logic [1:0]  r_need, n_need;
    logic [1:0]  r_held, n_held;
    logic [7:0]  r_cont0, r_cont1;

    logic        accept;
    logic        cont_ok, sec_ok, ok, handled, wr_cont;
    logic [1:0]  lead_need;
    logic [5:0]  t6;
    logic [20:0] cp_asm;
    t_job        job;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign cont_ok = (i_byte[7:6] == 2'b10);
    assign sec_ok  = !((r_lead == LEAD_E0 && i_byte <  CONT_A0) ||
                       (r_lead == LEAD_ED && i_byte >= CONT_A0) ||
                       (r_lead == LEAD_F0 && i_byte <  CONT_90) ||
                       (r_lead == LEAD_F4 && i_byte >  CONT_8F));
    assign ok      = cont_ok && ((r_held != 2'd0) || sec_ok);
    assign t6      = i_byte[5:0];

    always_comb begin
        if (r_lead <= LEAD2_HI) begin
            cp_asm = {10'd0, r_lead[4:0], t6};
        end else if (r_lead <= LEAD3_HI) begin
            cp_asm = {5'd0, r_lead[3:0], r_cont0[5:0], t6};
        end else begin
            cp_asm = {r_lead[2:0], r_cont0[5:0], r_cont1[5:0], t6};
        end
    end

    always_comb begin
        if (i_byte >= LEAD2_LO && i_byte <= LEAD2_HI) begin
            lead_need = 2'd1;
        end else if (i_byte >= LEAD_E0 && i_byte <= LEAD3_HI) begin
            lead_need = 2'd2;
        end else if (i_byte >= LEAD_F0 && i_byte <= LEAD_F4) begin
            lead_need = 2'd3;
        end else begin
            lead_need = 2'd0;
        end
    end

    always_comb begin
        n_lead   = r_lead;
        n_need   = r_need;
        n_held   = r_held;
        handled  = 1'b0;
        wr_cont  = 1'b0;
        job.n_repl = 2'd0;
        job.tail   = TAIL_NONE;
        job.cp     = '0;
        job.last   = i_last;

        if (r_need != 2'd0) begin
            if (ok && r_need == 2'd1) begin
                job.tail = (cp_asm[20:16] != 5'd0) ? TAIL_PAIR : TAIL_BMP;
                job.cp   = cp_asm;
                n_lead   = '0;
                n_need   = 2'd0;
                n_held   = 2'd0;
                handled  = 1'b1;
            end else if (ok && !i_last) begin
                n_held  = r_held + 2'd1;
                n_need  = r_need - 2'd1;
                wr_cont = 1'b1;
                handled = 1'b1;
            end else begin
                // replacement for the lead and every held continuation
                job.n_repl = r_held + 2'd1;
                n_lead     = '0;
                n_need     = 2'd0;
                n_held     = 2'd0;
            end
        end

        if (!handled) begin
            if (!i_byte[7]) begin
                job.tail = TAIL_BMP;
                job.cp   = {13'd0, i_byte};
            end else if (lead_need != 2'd0 && !i_last) begin
                n_lead = i_byte;
                n_need = lead_need;
                n_held = 2'd0;
            end else begin
                job.tail = TAIL_BMP;
                job.cp   = {5'd0, REPL_UNIT};
            end
        end
    end

    assign o_push = accept && ((job.n_repl != 2'd0) || (job.tail != TAIL_NONE));
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_need <= 2'd0;
            r_held <= 2'd0;
        end else if (accept) begin
            r_lead <= n_lead;
            r_need <= n_need;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_cont) begin
            if (r_held[0]) begin
                r_cont1 <= i_byte;
            end else begin
                r_cont0 <= i_byte;
            end
        end
    end

endmodule

### rtl/utd_queue.sv
// short job queue between front and back
module utd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utd_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output utd_pkg::t_job o_job
);
    import utd_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### rtl/utd_back.sv
// back end: expands one job into utf-16 code units, one per transfer
module utd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  utd_pkg::t_job i_job,
    output logic          o_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [15:0]   o_code_unit,
    output logic          o_run_end,
    output logic          o_string_end
);
    import utd_pkg::*;

    logic        r_busy;
    t_job        r_job;
    logic [1:0]  r_rep;
    logic        r_low;

    logic        xfer, fin, load;
    logic [20:0] v;

    assign v    = r_job.cp - SUPP_BASE;
    assign fin  = ((r_rep == 2'd0) && ((r_job.tail == TAIL_BMP) ||
                                       (r_job.tail == TAIL_PAIR && r_low))) ||
                  ((r_rep == 2'd1) && (r_job.tail == TAIL_NONE));
    assign xfer = r_busy && i_ready;
    assign load = i_valid && (!r_busy || (xfer && fin));
    assign o_pop = load;

    always_comb begin
        if (r_rep != 2'd0) begin
            o_code_unit = REPL_UNIT;
        end else if (r_job.tail == TAIL_PAIR) begin
            o_code_unit = r_low ? (SURR_LO_BASE | {6'd0, r_job.cp[9:0]})
                                : (SURR_HI_BASE | {6'd0, v[19:10]});
        end else begin
            o_code_unit = r_job.cp[15:0];
        end
    end

    assign o_valid      = r_busy;
    assign o_run_end    = fin;
    assign o_string_end = fin && r_job.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rep  <= 2'd0;
            r_low  <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_rep  <= i_job.n_repl;
            r_low  <= 1'b0;
        end else if (xfer) begin
            if (fin) begin
                r_busy <= 1'b0;
            end else if (r_rep != 2'd0) begin
                r_rep <= r_rep - 2'd1;
            end else begin
                r_low <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

endmodule

### rtl/utf8_to_utf16_decoder.sv
// top level of the utf-8 to utf-16 decoder
//
// Takes a utf-8 string one byte per transfer on i_in and emits utf-16 code units on
// o_out. A byte flagged in_last ends the string and flushes any pending sequence.
// Malformed or truncated input becomes U+FFFD, one per rejected lead and held
// continuation byte, and the byte that broke a sequence is decoded again as a new
// lead; code points above U+FFFF come out as a surrogate pair. run_end marks the
// final code unit caused by one input byte, string_end the final one of the string.
// Rate: the front takes one byte per cycle whenever the four-entry job queue has
// room; the back hands out one code unit per cycle while o_out is ready, and one
// byte yields 0 to 4 units, 2 for a surrogate pair. Sustained throughput is one
// byte per cycle for text whose bytes yield at most one unit each on average while
// o_out stays ready; longer bursts fill the job queue and stall i_in. A byte's
// first unit goes out once its job is written to the queue and loaded by the back.
module utf8_to_utf16_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utd_byte_if.sink   i_in,
    utd_unit_if.source o_out
);
    import utd_pkg::*;

    // front to queue
    logic push, full;
    t_job push_job;

    // queue to back
    logic pop, head_valid;
    t_job head_job;

    // byte validation and classification, keeps the pending sequence state
    utd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.in_last),
        .i_full  (full),
        .o_ready (i_in.ready),
        .o_push  (push),
        .o_job   (push_job)
    );

    // decouples byte intake from code unit output
    utd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    // expands each job into its code units
    utd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (head_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .i_ready      (o_out.ready),
        .o_valid      (o_out.valid),
        .o_code_unit  (o_out.code_unit),
        .o_run_end    (o_out.run_end),
        .o_string_end (o_out.string_end)
    );

endmodule

### tb/sv/utf8_to_utf16_decoder_tb.sv
// testbench of the utf-8 to utf-16 decoder: random and directed byte strings, checked unit by unit
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_tb;
    import utd_pkg::*;

    // long receiver hold-off, used once to back the block up into its input
    localparam int HOLD_CYCLES  = 200;
    localparam int TOTAL_BYTES  = 320;
    localparam int DRAIN_LIMIT  = 10000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;   // sender waits until every expected unit has come
    } t_byte_item;

    typedef struct packed {
        logic [15:0] unit;
        logic        run_end;
        logic        string_end;
    } t_unit_exp;

    logic i_clk;
    logic i_rst_n;

    utd_byte_if in_if ();
    utd_unit_if out_if ();

    utf8_to_utf16_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_byte_item stim_q[$];
    t_unit_exp  expected_units[$];
    t_byte_item drv_item;
    t_unit_exp  mon_exp;

    int n_total;
    int n_sent;
    int err_cnt;
    int hold_cnt;
    logic hold_done;

    // decoder state mirrored in the testbench
    logic [7:0] dec_lead;
    logic [7:0] dec_cont [2];
    logic [1:0] dec_need;
    logic [1:0] dec_held;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    // second byte limits: no overlong, no surrogate, nothing above U+10FFFF
    function automatic logic second_byte_ok(input logic [7:0] lead, input logic [7:0] b);
        if (lead == LEAD_E0 && b < CONT_A0) return 1'b0;
        if (lead == LEAD_ED && b >= CONT_A0) return 1'b0;
        if (lead == LEAD_F0 && b < CONT_90) return 1'b0;
        if (lead == LEAD_F4 && b > CONT_8F) return 1'b0;
        return 1'b1;
    endfunction

    // advance the mirrored state by one byte and queue the code units it causes
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [15:0] u [4];
        int          n;
        int          h;
        int          k;
        logic        ok;
        logic        done;
        logic [1:0]  need;
        logic [20:0] cp;
        logic [20:0] v;
        t_unit_exp   e;
        n    = 0;
        done = 1'b0;
        if (dec_need != 2'd0) begin
            ok = (b[7:6] == 2'b10);
            if (ok && dec_held == 2'd0) ok = second_byte_ok(dec_lead, b);
            if (ok && dec_need == 2'd1) begin
                // sequence complete
                if (dec_lead <= LEAD2_HI)
                    cp = {10'd0, dec_lead[4:0], b[5:0]};
                else if (dec_lead <= LEAD3_HI)
                    cp = {5'd0, dec_lead[3:0], dec_cont[0][5:0], b[5:0]};
                else
                    cp = {dec_lead[2:0], dec_cont[0][5:0], dec_cont[1][5:0], b[5:0]};
                if (cp <= 21'h00FFFF) begin
                    u[n] = cp[15:0];
                    n++;
                end else begin
                    v = cp - SUPP_BASE;
                    u[n] = SURR_HI_BASE + {6'd0, v[19:10]};
                    n++;
                    u[n] = SURR_LO_BASE + {6'd0, v[9:0]};
                    n++;
                end
                dec_need = 2'd0;
                dec_held = 2'd0;
                dec_lead = 8'h00;
                done = 1'b1;
            end else if (ok && !last && dec_held < 2'd2) begin
                dec_cont[dec_held[0]] = b;
                dec_held = dec_held + 2'd1;
                dec_need = dec_need - 2'd1;
                done = 1'b1;
            end else begin
                // broken or truncated: one replacement for the lead and each held byte
                u[n] = REPL_UNIT;
                n++;
                for (h = 0; h < dec_held; h++) begin
                    u[n] = REPL_UNIT;
                    n++;
                end
                dec_need = 2'd0;
                dec_held = 2'd0;
                dec_lead = 8'h00;
            end
        end
        if (!done) begin
            // byte taken as a new lead
            if (!b[7]) begin
                u[n] = {8'h00, b};
                n++;
            end else begin
                need = 2'd0;
                if (b >= LEAD2_LO && b <= LEAD2_HI) need = 2'd1;
                else if (b >= LEAD_E0 && b <= LEAD3_HI) need = 2'd2;
                else if (b >= LEAD_F0 && b <= LEAD_F4) need = 2'd3;
                if (need == 2'd0 || last) begin
                    u[n] = REPL_UNIT;
                    n++;
                end else begin
                    dec_lead = b;
                    dec_need = need;
                    dec_held = 2'd0;
                end
            end
        end
        for (k = 0; k < n; k++) begin
            e.unit       = u[k];
            e.run_end    = (k == n - 1);
            e.string_end = (k == n - 1) && last;
            expected_units.push_back(e);
        end
    endtask

    task automatic push_item(input logic [7:0] data, input logic last, input logic drain);
        t_byte_item it;
        it.data  = data;
        it.last  = last;
        it.drain = drain;
        stim_q.push_back(it);
    endtask

    // random scalar value of one utf-8 length class, extremes favored
    function automatic logic [20:0] rand_code_point(input int cls);
        int lo;
        int hi;
        logic [20:0] cp;
        case (cls)
            0:       begin lo = 'h0;     hi = 'h7F;     end
            1:       begin lo = 'h80;    hi = 'h7FF;    end
            2:       begin lo = 'h800;   hi = 'hFFFF;   end
            default: begin lo = 'h10000; hi = 'h10FFFF; end
        endcase
        if ($urandom_range(0, 3) == 0)
            cp = $urandom_range(0, 1) ? hi[20:0] : lo[20:0];
        else
            cp = 21'($urandom_range(lo, hi));
        // surrogates are not scalar values, move them up into F800-FFFF
        if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp ^ 21'h002000;
        return cp;
    endfunction

    // utf-8 encoding, first byte in the top bits of enc
    function automatic int utf8_encode(input logic [20:0] cp, output logic [31:0] enc);
        if (cp < 21'h80) begin
            enc = {1'b0, cp[6:0], 24'h0};
            return 1;
        end else if (cp < 21'h800) begin
            enc = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
            return 2;
        end else if (cp < 21'h10000) begin
            enc = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
            return 3;
        end
        enc = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
        return 4;
    endfunction

    // one string: mostly well-formed characters, some broken sequences and noise
    task automatic gen_string(input logic force_drain);
        logic [7:0]  sbuf [48];
        logic [31:0] enc;
        logic        drain;
        int          len;
        int          nchars;
        int          i;
        int          k;
        int          j;
        int          r;
        int          n;
        len    = 0;
        nchars = $urandom_range(1, 8);
        for (i = 0; i < nchars; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                n = utf8_encode(rand_code_point($urandom_range(0, 3)), enc);
            end else if (r < 88) begin
                k = $urandom_range(0, 2);
                if (k == 2) begin
                    // lead with a second byte limit, continuations anywhere in 80-BF
                    case ($urandom_range(0, 3))
                        0:       enc[31:24] = LEAD_E0;
                        1:       enc[31:24] = LEAD_ED;
                        2:       enc[31:24] = LEAD_F0;
                        default: enc[31:24] = LEAD_F4;
                    endcase
                    enc[23:16] = {2'b10, 6'($urandom_range(0, 63))};
                    enc[15:8]  = {2'b10, 6'($urandom_range(0, 63))};
                    enc[7:0]   = {2'b10, 6'($urandom_range(0, 63))};
                    n = $urandom_range(2, 4);
                end else begin
                    n = utf8_encode(rand_code_point($urandom_range(1, 3)), enc);
                    if (k == 0) begin
                        n = $urandom_range(1, n - 1);  // truncated sequence
                    end else begin
                        j = $urandom_range(1, n - 1);  // corrupted continuation
                        enc[31 - 8 * j -: 8] = 8'($urandom_range(0, 255));
                    end
                end
            end else begin
                enc = {8'($urandom_range(0, 255)), 24'h0};
                n = 1;
            end
            for (k = 0; k < n; k++) begin
                sbuf[len] = enc[31 - 8 * k -: 8];
                len++;
            end
        end
        drain = force_drain || ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++)
            push_item(sbuf[k], k == len - 1, drain && k == 0);
    endtask

    // idle percentage of one side in the current phase of the run
    function automatic int idle_pct(input logic sender);
        if (n_sent < n_total / 3) return sender ? 19 : 58;
        if (n_sent < 2 * n_total / 3) return sender ? 58 : 19;
        return 0;
    endfunction

    // byte driver: takes the prediction at each transfer, then offers the next byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.in_byte <= 8'h00;
            in_if.in_last <= 1'b0;
            n_sent        <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.in_byte, in_if.in_last);
                n_sent <= n_sent + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (stim_q.size() != 0) drv_item = stim_q[0];
                if (stim_q.size() != 0 && !(drv_item.drain && expected_units.size() != 0)
                        && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                    drv_item = stim_q.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.in_byte <= drv_item.data;
                    in_if.in_last <= drv_item.last;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off late in the run, when the sender no longer idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_sent >= n_total * 5 / 6) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // code unit monitor: each transfer checked against the oldest expected unit
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_units.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected code unit %h run_end %b string_end %b",
                                 out_if.code_unit, out_if.run_end, out_if.string_end);
                end else begin
                    mon_exp = expected_units.pop_front();
                    if (out_if.code_unit !== mon_exp.unit || out_if.run_end !== mon_exp.run_end
                            || out_if.string_end !== mon_exp.string_end) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     mon_exp.unit, mon_exp.run_end, mon_exp.string_end,
                                     out_if.code_unit, out_if.run_end, out_if.string_end);
                    end
                end
            end
            out_if.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= idle_pct(1'b0));
        end
    end

    // stimulus, reset and end of run
    initial begin
        int wait_cnt;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.in_last = 1'b0;
        out_if.ready  = 1'b0;
        err_cnt       = 0;
        n_sent        = 0;
        n_total       = 0;
        dec_lead      = 8'h00;
        dec_cont[0]   = 8'h00;
        dec_cont[1]   = 8'h00;
        dec_need      = 2'd0;
        dec_held      = 2'd0;

        // ascii extremes, shortest 2 and 3 byte forms, U+10FFFF as a surrogate pair
        push_item(8'h00, 0, 0); push_item(8'h7F, 0, 0);
        push_item(8'hC2, 0, 0); push_item(8'h80, 0, 0);
        push_item(8'hE0, 0, 0); push_item(8'hA0, 0, 0); push_item(8'h80, 0, 0);
        push_item(8'hF4, 0, 0); push_item(8'h8F, 0, 0); push_item(8'hBF, 0, 0);
        push_item(8'hBF, 1, 0);
        // overlong, surrogate and out-of-range second bytes, bad leads,
        // failure with two held bytes, then a string cut short mid-sequence
        push_item(8'hE0, 0, 0); push_item(8'h9F, 0, 0);
        push_item(8'hED, 0, 0); push_item(8'hA0, 0, 0);
        push_item(8'hF4, 0, 0); push_item(8'h90, 0, 0);
        push_item(8'hF5, 0, 0); push_item(8'hC1, 0, 0);
        push_item(8'hF0, 0, 0); push_item(8'h90, 0, 0); push_item(8'h80, 0, 0);
        push_item(8'h41, 0, 0);
        push_item(8'hE2, 0, 0); push_item(8'h82, 1, 0);
        // lead byte that ends the string
        push_item(8'hC3, 1, 0);

        n_total = TOTAL_BYTES;
        gen_string(1'b1);
        while (stim_q.size() < n_total) gen_string(1'b0);
        n_total = stim_q.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every byte handed over, then every expected unit seen
        while (stim_q.size() != 0 || in_if.valid) @(posedge i_clk);
        wait_cnt = 0;
        while (expected_units.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (16) @(posedge i_clk);

        if (err_cnt == 0 && expected_units.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### utf8_to_utf16_decoder.f
rtl/utd_pkg.sv
rtl/utd_byte_if.sv
rtl/utd_unit_if.sv
rtl/utd_front.sv
rtl/utd_queue.sv
rtl/utd_back.sv
rtl/utf8_to_utf16_decoder.sv
tb/sv/utf8_to_utf16_decoder_tb.sv
